/* hdl/irpdt_pkg.sv */
// Shared types, constants and helpers for the IR pulse-distance transmitter.
// No dependencies; used by irpdt_seq and ir_pulse_distance_transmitter.
package irpdt_pkg;

    // Frame geometry
    localparam int CODE_BITS = 32;
    localparam int CodeW     = 32;
    localparam int BitPosW   = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    // Segment counter and register widths
    localparam int TickW     = 20;
    localparam int SegW      = 16;

    // Configuration port
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 20;

    localparam logic [CfgAddrW-1:0] REG_LEADER_HIGH = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_LEADER_LOW  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_BIT_HIGH    = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_ZERO_LOW    = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_ONE_LOW     = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_GAP         = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_REPEAT      = 3'd6;

    // Register reset values
    localparam logic [SegW-1:0]  RST_LEADER_HIGH = 16'd9000;
    localparam logic [SegW-1:0]  RST_LEADER_LOW  = 16'd4500;
    localparam logic [SegW-1:0]  RST_BIT_HIGH    = 16'd500;
    localparam logic [SegW-1:0]  RST_ZERO_LOW    = 16'd500;
    localparam logic [SegW-1:0]  RST_ONE_LOW     = 16'd1620;
    localparam logic [TickW-1:0] RST_GAP         = 20'd100000;
    localparam logic             RST_REPEAT      = 1'b1;

    // Frame phases
    localparam int PhaseW = 3;
    localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
    localparam logic [PhaseW-1:0] PH_LEAD_H = 3'd1;
    localparam logic [PhaseW-1:0] PH_LEAD_L = 3'd2;
    localparam logic [PhaseW-1:0] PH_BIT_H  = 3'd3;
    localparam logic [PhaseW-1:0] PH_BIT_L  = 3'd4;
    localparam logic [PhaseW-1:0] PH_GAP    = 3'd5;

    // Input opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [SegW-1:0]  leader_high_ticks;
        logic [SegW-1:0]  leader_low_ticks;
        logic [SegW-1:0]  bit_high_ticks;
        logic [SegW-1:0]  zero_low_ticks;
        logic [SegW-1:0]  one_low_ticks;
        logic [TickW-1:0] gap_ticks;
        logic             repeat_enable;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_end;
    } seq_res_t;

    // Segment length: zero counts as one tick
    function automatic logic [TickW-1:0] seg_len(input logic [TickW-1:0] v);
        return (v == '0) ? TickW'(1) : v;
    endfunction

    // Code bit sent at a bit position, MSB first; positions past bit 31 send 0
    function automatic logic code_bit(input logic [CodeW-1:0]   code,
                                      input logic [BitPosW-1:0] pos);
        logic [7:0] k;
        k = 8'(CODE_BITS - 1) - 8'(pos);
        return (k >= 8'(CodeW)) ? 1'b0 : code[k[4:0]];
    endfunction

endpackage

/* hdl/irpdt_seq.sv */
// Frame sequencer: phase, segment down-counter, bit position and held code.
// Depends on irpdt_pkg. Advances once per accepted item, result is combinational.
module irpdt_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,     // item accepted this cycle
    input  logic                          opcode,
    input  logic [irpdt_pkg::CodeW-1:0]   code,
    input  irpdt_pkg::cfg_t               cfg,
    output irpdt_pkg::seq_res_t           res
);

    logic [irpdt_pkg::PhaseW-1:0]  phase_reg, phase_next;
    logic [irpdt_pkg::TickW-1:0]   ticks_reg, ticks_next;
    logic [irpdt_pkg::BitPosW-1:0] bitpos_reg, bitpos_next;
    logic [irpdt_pkg::CodeW-1:0]   code_reg, code_next;

    logic                          seg_done;
    logic                          last_bit;

    assign seg_done = (ticks_reg <= irpdt_pkg::TickW'(1));
    assign last_bit = (bitpos_reg == irpdt_pkg::BitPosW'(irpdt_pkg::CODE_BITS - 1));

    // Next state and result for the presented item
    always_comb begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        bitpos_next = bitpos_reg;
        code_next   = code_reg;
        res         = '0;

        if (opcode == irpdt_pkg::OP_START) begin
            // restart the frame at once; no time passes
            code_next     = code;
            bitpos_next   = '0;
            phase_next    = irpdt_pkg::PH_LEAD_H;
            ticks_next    = irpdt_pkg::seg_len(
                                irpdt_pkg::TickW'(cfg.leader_high_ticks));
            res.pin_level = 1'b1;
            res.busy_res  = 1'b1;
        end else begin
            unique case (phase_reg)
                irpdt_pkg::PH_LEAD_H, irpdt_pkg::PH_LEAD_L, irpdt_pkg::PH_BIT_H,
                irpdt_pkg::PH_BIT_L, irpdt_pkg::PH_GAP: begin
                    res.busy_res  = 1'b1;
                    res.pin_level = (phase_reg == irpdt_pkg::PH_LEAD_H) ||
                                    (phase_reg == irpdt_pkg::PH_BIT_H);
                    if (!seg_done) begin
                        ticks_next = ticks_reg - irpdt_pkg::TickW'(1);
                    end else begin
                        unique case (phase_reg)
                            irpdt_pkg::PH_LEAD_H: begin
                                phase_next = irpdt_pkg::PH_LEAD_L;
                                ticks_next = irpdt_pkg::seg_len(
                                    irpdt_pkg::TickW'(cfg.leader_low_ticks));
                            end
                            irpdt_pkg::PH_LEAD_L: begin
                                bitpos_next = '0;
                                phase_next  = irpdt_pkg::PH_BIT_H;
                                ticks_next  = irpdt_pkg::seg_len(
                                    irpdt_pkg::TickW'(cfg.bit_high_ticks));
                            end
                            irpdt_pkg::PH_BIT_H: begin
                                phase_next = irpdt_pkg::PH_BIT_L;
                                ticks_next = irpdt_pkg::code_bit(code_reg, bitpos_reg)
                                    ? irpdt_pkg::seg_len(
                                          irpdt_pkg::TickW'(cfg.one_low_ticks))
                                    : irpdt_pkg::seg_len(
                                          irpdt_pkg::TickW'(cfg.zero_low_ticks));
                            end
                            irpdt_pkg::PH_BIT_L: begin
                                if (last_bit) begin
                                    phase_next = irpdt_pkg::PH_GAP;
                                    ticks_next = irpdt_pkg::seg_len(cfg.gap_ticks);
                                end else begin
                                    bitpos_next = bitpos_reg + irpdt_pkg::BitPosW'(1);
                                    phase_next  = irpdt_pkg::PH_BIT_H;
                                    ticks_next  = irpdt_pkg::seg_len(
                                        irpdt_pkg::TickW'(cfg.bit_high_ticks));
                                end
                            end
                            default: begin
                                // end of trailing gap
                                res.frame_end = 1'b1;
                                bitpos_next   = '0;
                                if (cfg.repeat_enable) begin
                                    phase_next = irpdt_pkg::PH_LEAD_H;
                                    ticks_next = irpdt_pkg::seg_len(
                                        irpdt_pkg::TickW'(cfg.leader_high_ticks));
                                end else begin
                                    phase_next = irpdt_pkg::PH_IDLE;
                                    ticks_next = '0;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    phase_next = irpdt_pkg::PH_IDLE;
                    ticks_next = '0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= irpdt_pkg::PH_IDLE;
            ticks_reg  <= '0;
            bitpos_reg <= '0;
            code_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            bitpos_reg <= bitpos_next;
            code_reg   <= code_next;
        end
    end

endmodule

/* hdl/ir_pulse_distance_transmitter.sv */
// Top level of the IR pulse-distance transmitter: config registers, stream
// handshake and result register. Depends on irpdt_pkg and irpdt_seq.
//
//  Channel  | Direction | Payload                              | Handshake
//  ---------+-----------+--------------------------------------+---------------
//  s_       | in        | tuser: opcode; tdata: code           | tvalid/tready
//  m_       | out       | tdata: pin_level, busy_res; tlast:   | tvalid/tready
//           |           | frame_end                            |
//  cfg_     | in        | addr: register index; wdata: value   | cfg_we
//
// One item per cycle while s_tready is high: an accepted item updates the
// sequencer state in the same cycle and its result is in the output register
// in the next cycle. s_tready is low only while the output register holds an
// untaken result and m_tready is low, and during reset. aresetn is synchronous,
// active low; it clears the sequencer to idle and loads the register defaults.
module ir_pulse_distance_transmitter (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] code
    input  logic [0:0]                      s_tuser,   // [0] opcode

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [0] pin_level, [1] busy_res
    output logic                            m_tlast,   // frame_end

    input  logic                            cfg_we,
    input  logic [irpdt_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [irpdt_pkg::CfgDataW-1:0]  cfg_wdata
);

    irpdt_pkg::cfg_t     cfg_reg;
    irpdt_pkg::seq_res_t seq_res;
    irpdt_pkg::seq_res_t res_reg;
    logic                m_valid_reg;
    logic                s_xfer;

    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_high_ticks <= irpdt_pkg::RST_LEADER_HIGH;
            cfg_reg.leader_low_ticks  <= irpdt_pkg::RST_LEADER_LOW;
            cfg_reg.bit_high_ticks    <= irpdt_pkg::RST_BIT_HIGH;
            cfg_reg.zero_low_ticks    <= irpdt_pkg::RST_ZERO_LOW;
            cfg_reg.one_low_ticks     <= irpdt_pkg::RST_ONE_LOW;
            cfg_reg.gap_ticks         <= irpdt_pkg::RST_GAP;
            cfg_reg.repeat_enable     <= irpdt_pkg::RST_REPEAT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                irpdt_pkg::REG_LEADER_HIGH:
                    cfg_reg.leader_high_ticks <= cfg_wdata[irpdt_pkg::SegW-1:0];
                irpdt_pkg::REG_LEADER_LOW:
                    cfg_reg.leader_low_ticks  <= cfg_wdata[irpdt_pkg::SegW-1:0];
                irpdt_pkg::REG_BIT_HIGH:
                    cfg_reg.bit_high_ticks    <= cfg_wdata[irpdt_pkg::SegW-1:0];
                irpdt_pkg::REG_ZERO_LOW:
                    cfg_reg.zero_low_ticks    <= cfg_wdata[irpdt_pkg::SegW-1:0];
                irpdt_pkg::REG_ONE_LOW:
                    cfg_reg.one_low_ticks     <= cfg_wdata[irpdt_pkg::SegW-1:0];
                irpdt_pkg::REG_GAP:
                    cfg_reg.gap_ticks         <= cfg_wdata[irpdt_pkg::TickW-1:0];
                irpdt_pkg::REG_REPEAT:
                    cfg_reg.repeat_enable     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Frame sequencer
    irpdt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_xfer),
        .opcode  (s_tuser[0]),
        .code    (s_tdata),
        .cfg     (cfg_reg),
        .res     (seq_res)
    );

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= seq_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, res_reg.busy_res, res_reg.pin_level};
    assign m_tlast  = res_reg.frame_end;

    // A start transfer drives the pin high and marks busy on its result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser[0] == irpdt_pkg::OP_START)
            |=> (m_tvalid && m_tdata[0] && m_tdata[1] && !m_tlast))
        else $error("start result not high/busy");

    // Every accepted item yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid)
        else $error("accepted item produced no result");

    // Frame end only while busy; pin never high while not busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((!m_tlast || m_tdata[1]) && (!m_tdata[0] || m_tdata[1])))
        else $error("frame_end or pin high outside a frame");

endmodule

/* bench/tb_ir_pulse_distance_transmitter.sv */
// Self-checking bench for the IR pulse-distance transmitter: drives tick/start
// transfers, predicts pin level, busy and frame end per tick, checks each result.
// Depends on irpdt_pkg and the ir_pulse_distance_transmitter RTL.
module tb_ir_pulse_distance_transmitter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int STALL_CYCLES  = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES    = 8;

    // Kinds of timing setup per phase
    localparam int TIMING_MIN   = 0;
    localparam int TIMING_MAX   = 1;
    localparam int TIMING_SHORT = 2;

    // Tracks the transmitter's frame state and the pin results it owes
    class pin_track_scoreboard;
        irpdt_pkg::cfg_t                        timing;
        logic [irpdt_pkg::PhaseW-1:0]           seg_phase;
        logic [irpdt_pkg::TickW-1:0]            seg_left;
        int unsigned                            bit_idx;
        logic [irpdt_pkg::CodeW-1:0]            code_word;
        irpdt_pkg::seq_res_t                    pin_expected[$];
        int unsigned                            failures;

        function new();
            timing.leader_high_ticks = irpdt_pkg::RST_LEADER_HIGH;
            timing.leader_low_ticks  = irpdt_pkg::RST_LEADER_LOW;
            timing.bit_high_ticks    = irpdt_pkg::RST_BIT_HIGH;
            timing.zero_low_ticks    = irpdt_pkg::RST_ZERO_LOW;
            timing.one_low_ticks     = irpdt_pkg::RST_ONE_LOW;
            timing.gap_ticks         = irpdt_pkg::RST_GAP;
            timing.repeat_enable     = irpdt_pkg::RST_REPEAT;
            seg_phase = irpdt_pkg::PH_IDLE;
            seg_left  = '0;
            bit_idx   = 0;
            code_word = '0;
            failures  = 0;
        endfunction

        // A zero length still lasts one tick
        function void load_segment(logic [irpdt_pkg::PhaseW-1:0] ph,
                                   logic [irpdt_pkg::TickW-1:0] len);
            seg_phase = ph;
            seg_left  = (len == '0) ? irpdt_pkg::TickW'(1) : len;
        endfunction

        function logic sent_bit();
            int k;
            k = irpdt_pkg::CODE_BITS - 1 - int'(bit_idx);
            return (k < irpdt_pkg::CodeW) ? code_word[k[4:0]] : 1'b0;
        endfunction

        function bit frame_idle();
            return seg_phase == irpdt_pkg::PH_IDLE;
        endfunction

        function int pending();
            return pin_expected.size();
        endfunction

        // Advance the predicted frame by one accepted transfer
        function void note_input(logic op, logic [irpdt_pkg::CodeW-1:0] code);
            irpdt_pkg::seq_res_t want;
            want = '0;
            if (op == irpdt_pkg::OP_START) begin
                // restart: leader burst level reported, no time passes
                code_word = code;
                bit_idx   = 0;
                load_segment(irpdt_pkg::PH_LEAD_H,
                             irpdt_pkg::TickW'(timing.leader_high_ticks));
                want.pin_level = 1'b1;
                want.busy_res  = 1'b1;
            end else if (seg_phase != irpdt_pkg::PH_IDLE) begin
                want.busy_res  = 1'b1;
                want.pin_level = (seg_phase == irpdt_pkg::PH_LEAD_H) ||
                                 (seg_phase == irpdt_pkg::PH_BIT_H);
                if (seg_left > irpdt_pkg::TickW'(1)) begin
                    seg_left = seg_left - irpdt_pkg::TickW'(1);
                end else begin
                    case (seg_phase)
                        irpdt_pkg::PH_LEAD_H: begin
                            load_segment(irpdt_pkg::PH_LEAD_L,
                                         irpdt_pkg::TickW'(timing.leader_low_ticks));
                        end
                        irpdt_pkg::PH_LEAD_L: begin
                            bit_idx = 0;
                            load_segment(irpdt_pkg::PH_BIT_H,
                                         irpdt_pkg::TickW'(timing.bit_high_ticks));
                        end
                        irpdt_pkg::PH_BIT_H: begin
                            load_segment(irpdt_pkg::PH_BIT_L, sent_bit()
                                ? irpdt_pkg::TickW'(timing.one_low_ticks)
                                : irpdt_pkg::TickW'(timing.zero_low_ticks));
                        end
                        irpdt_pkg::PH_BIT_L: begin
                            if (bit_idx + 1 >= irpdt_pkg::CODE_BITS) begin
                                load_segment(irpdt_pkg::PH_GAP, timing.gap_ticks);
                            end else begin
                                bit_idx = bit_idx + 1;
                                load_segment(irpdt_pkg::PH_BIT_H,
                                             irpdt_pkg::TickW'(timing.bit_high_ticks));
                            end
                        end
                        default: begin
                            // end of trailing gap
                            want.frame_end = 1'b1;
                            bit_idx = 0;
                            if (timing.repeat_enable) begin
                                load_segment(irpdt_pkg::PH_LEAD_H,
                                             irpdt_pkg::TickW'(timing.leader_high_ticks));
                            end else begin
                                seg_phase = irpdt_pkg::PH_IDLE;
                                seg_left  = '0;
                            end
                        end
                    endcase
                end
            end
            pin_expected.push_back(want);
        endfunction

        function void check_result(logic pin, logic busy, logic fend);
            irpdt_pkg::seq_res_t want;
            if (pin_expected.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with none outstanding: pin %0b busy %0b end %0b",
                             $realtime, pin, busy, fend);
                return;
            end
            want = pin_expected.pop_front();
            if (pin !== want.pin_level || busy !== want.busy_res ||
                fend !== want.frame_end) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch pin %0b/%0b busy %0b/%0b end %0b/%0b (exp/got)",
                             $realtime, want.pin_level, pin, want.busy_res, busy,
                             want.frame_end, fend);
            end
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata   = '0;
    logic [0:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            m_tlast;
    logic                            cfg_we    = 1'b0;
    logic [irpdt_pkg::CfgAddrW-1:0]  cfg_addr  = '0;
    logic [irpdt_pkg::CfgDataW-1:0]  cfg_wdata = '0;

    pin_track_scoreboard sb;
    int unsigned src_idle_pct  = 14;
    int unsigned sink_idle_pct = 51;
    int unsigned cycle_count   = 0;
    logic        stall_tog     = 1'b0;
    logic        stall_seen    = 1'b0;
    int unsigned stall_left    = 0;

    ir_pulse_distance_transmitter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, random backpressure, long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[0], m_tdata[1], m_tlast);
        if (stall_tog != stall_seen) begin
            stall_seen <= stall_tog;
            stall_left <= STALL_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // One input transfer; each cycle in front may be idle
    task automatic send_item(input logic op, input logic [31:0] code);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, code);
    endtask

    // Mostly ticks; starts are common when idle and rare mid-frame
    task automatic random_item();
        logic        op;
        logic [31:0] code;
        if (sb.frame_idle())
            op = ($urandom_range(99) < 25) ? irpdt_pkg::OP_START : irpdt_pkg::OP_TICK;
        else
            op = ($urandom_range(999) < 4) ? irpdt_pkg::OP_START : irpdt_pkg::OP_TICK;
        code = $urandom();
        send_item(op, code);
    endtask

    // Stop sending and wait until every owed result is in
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all seven timing registers back to back
    task automatic load_timing(input irpdt_pkg::cfg_t c);
        logic [irpdt_pkg::CfgAddrW-1:0] idx [7];
        logic [irpdt_pkg::CfgDataW-1:0] val [7];
        idx = '{irpdt_pkg::REG_LEADER_HIGH, irpdt_pkg::REG_LEADER_LOW,
                irpdt_pkg::REG_BIT_HIGH, irpdt_pkg::REG_ZERO_LOW,
                irpdt_pkg::REG_ONE_LOW, irpdt_pkg::REG_GAP, irpdt_pkg::REG_REPEAT};
        val[0] = irpdt_pkg::CfgDataW'(c.leader_high_ticks);
        val[1] = irpdt_pkg::CfgDataW'(c.leader_low_ticks);
        val[2] = irpdt_pkg::CfgDataW'(c.bit_high_ticks);
        val[3] = irpdt_pkg::CfgDataW'(c.zero_low_ticks);
        val[4] = irpdt_pkg::CfgDataW'(c.one_low_ticks);
        val[5] = irpdt_pkg::CfgDataW'(c.gap_ticks);
        val[6] = irpdt_pkg::CfgDataW'(c.repeat_enable);
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_we   <= 1'b0;
        sb.timing = c;
    endtask

    function automatic irpdt_pkg::cfg_t pick_timing(int kind);
        irpdt_pkg::cfg_t c;
        case (kind)
            TIMING_MIN: begin
                // all zero: every segment lasts one tick
                c = '0;
            end
            TIMING_MAX: begin
                c.leader_high_ticks = '1;
                c.leader_low_ticks  = '1;
                c.bit_high_ticks    = '1;
                c.zero_low_ticks    = '1;
                c.one_low_ticks     = '1;
                c.gap_ticks         = '1;
                c.repeat_enable     = 1'b1;
            end
            default: begin
                // short segments so frames finish often
                c.leader_high_ticks = irpdt_pkg::SegW'($urandom_range(0, 6));
                c.leader_low_ticks  = irpdt_pkg::SegW'($urandom_range(0, 6));
                c.bit_high_ticks    = irpdt_pkg::SegW'($urandom_range(0, 3));
                c.zero_low_ticks    = irpdt_pkg::SegW'($urandom_range(0, 3));
                c.one_low_ticks     = irpdt_pkg::SegW'($urandom_range(1, 6));
                c.gap_ticks         = irpdt_pkg::TickW'($urandom_range(0, 10));
                c.repeat_enable     = 1'($urandom_range(1));
            end
        endcase
        return c;
    endfunction

    initial begin
        int kind;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle ticks, start at reset timing, restart mid-frame
        send_item(irpdt_pkg::OP_TICK, 32'h0000_0000);
        send_item(irpdt_pkg::OP_TICK, 32'hFFFF_FFFF);
        send_item(irpdt_pkg::OP_START, 32'hFFFF_FFFF);
        repeat (3) send_item(irpdt_pkg::OP_TICK, 32'h0000_0000);
        send_item(irpdt_pkg::OP_START, 32'h0000_0000);
        repeat (2) send_item(irpdt_pkg::OP_TICK, 32'hFFFF_FFFF);
        send_item(irpdt_pkg::OP_START, 32'h8000_0001);
        send_item(irpdt_pkg::OP_START, 32'h5A5A_A5A5);
        repeat (2) send_item(irpdt_pkg::OP_TICK, 32'h1234_5678);

        // Random phases; timing rewritten while idle on the bus, maybe mid-frame
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph >= 6) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else if (ph >= 3) begin
                src_idle_pct  = 51;
                sink_idle_pct = 14;
            end else begin
                src_idle_pct  = 14;
                sink_idle_pct = 51;
            end
            drain_results();
            kind = (ph == 0) ? TIMING_MIN : (ph == 1 || ph == 4) ? TIMING_MAX : TIMING_SHORT;
            load_timing(pick_timing(kind));
            // long receiver hold-off while the sender keeps offering
            if (ph == 2)
                stall_tog <= ~stall_tog;
            repeat ((kind == TIMING_MAX) ? 80 : 250) random_item();
        end

        drain_results();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
